### sv/bb3_pkg.sv
package bb3_pkg;

  localparam int BB3_MAX_WIDTH   = 2048;
  localparam int BB3_PIX_W       = 24;
  localparam int BB3_CFG_DATA_W  = 16;
  localparam int BB3_CFG_INDEX_W = 8;

  // configuration register indexes
  localparam logic [BB3_CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
  localparam logic [BB3_CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;

  localparam logic [11:0] WIDTH_RESET  = 12'd640;
  localparam logic [15:0] HEIGHT_RESET = 16'd480;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT,
    ST_SUM,
    ST_MUL,
    ST_DIV
  } bb3_state_t;

  // controller to datapath
  typedef struct packed {
    logic       accept;
    logic       shift;
    logic       sum;
    logic       mul;
    logic       load;
    logic       last;
    logic [1:0] k;
  } bb3_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [3:0] emit_mask;
    logic       out_free;
  } bb3_sts_t;

  // floor(2^16 / (2n)) for the rounded mean over n pixels
  function automatic logic [15:0] bb3_recip(input logic [3:0] n);
    logic [15:0] m;
    case (n)
      4'd1:    m = 16'd32768;
      4'd2:    m = 16'd16384;
      4'd3:    m = 16'd10922;
      4'd4:    m = 16'd8192;
      4'd5:    m = 16'd6553;
      4'd6:    m = 16'd5461;
      4'd7:    m = 16'd4681;
      4'd8:    m = 16'd4096;
      4'd9:    m = 16'd3640;
      default: m = 16'd32768;
    endcase
    return m;
  endfunction

endpackage

### sv/box_blur_3x3_edge_aware.sv
// channel  direction  beats
// in_      slave      one RGB pixel per beat, raster order
// out_     master     one blurred RGB pixel per beat; tlast ends a pixel's results
// cfg_     slave      register index and data, always ready
//
// An input pixel passes through a line buffer read and a window shift, then, for
// each result it causes (0 to 4), through sum, reciprocal multiply and
// remainder correction in one shared arithmetic path.
// The output register lets the next pixel be taken while a result waits.
// A stalled output holds the arithmetic path in its last stage.
// rst_n is synchronous; line buffers are not cleared.
module box_blur_3x3_edge_aware #(
  parameter int MAX_WIDTH = bb3_pkg::BB3_MAX_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bb3_pkg::BB3_PIX_W-1:0]       in_tdata,   // pixel_red, pixel_green, pixel_blue
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bb3_pkg::BB3_PIX_W-1:0]       out_tdata,  // blur_red, blur_green, blur_blue
  output logic                                out_tlast,  // run_last
  output logic                                out_tuser,  // frame_last
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bb3_pkg::BB3_CFG_INDEX_W-1:0] cfg_index,
  input  logic [bb3_pkg::BB3_CFG_DATA_W-1:0]  cfg_data
);
  import bb3_pkg::*;

  bb3_cmd_t cmd;
  bb3_sts_t sts;

  assign cfg_ready = 1'b1;

  bb3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bb3_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTH
  // one pixel at a time
  a_one_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("pixel accepted while another is in work");

  // frame end closes the pixel's results
  a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("frame end without run end");

  // no result is loaded before the pixel work has started
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !in_tready)
    else $error("result loaded while idle");
`endif

endmodule

### sv/bb3_ctrl.sv
module bb3_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  bb3_pkg::bb3_sts_t sts,
  output bb3_pkg::bb3_cmd_t cmd
);
  import bb3_pkg::*;

  bb3_state_t state_r, state_nxt;
  logic [3:0] mask_r, mask_nxt;
  logic [1:0] k_r, k_nxt;

  // lowest pending result slot
  function automatic logic [1:0] first_idx(input logic [3:0] m);
    logic [1:0] i;
    if (m[0])      i = 2'd0;
    else if (m[1]) i = 2'd1;
    else if (m[2]) i = 2'd2;
    else           i = 2'd3;
    return i;
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    mask_nxt  = mask_r;
    k_nxt     = k_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_READ;
      end
      ST_READ: state_nxt = ST_SHIFT;
      ST_SHIFT: begin
        if (sts.emit_mask != 4'd0) begin
          k_nxt     = first_idx(sts.emit_mask);
          mask_nxt  = sts.emit_mask & ~(4'd1 << first_idx(sts.emit_mask));
          state_nxt = ST_SUM;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SUM: state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_DIV;
      ST_DIV: begin
        if (sts.out_free) begin
          if (mask_r != 4'd0) begin
            k_nxt     = first_idx(mask_r);
            mask_nxt  = mask_r & ~(4'd1 << first_idx(mask_r));
            state_nxt = ST_SUM;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    cmd.k      = k_r;
    cmd.last   = (mask_r == 4'd0);
    in_tready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      ST_SHIFT: cmd.shift = 1'b1;
      ST_SUM:   cmd.sum   = 1'b1;
      ST_MUL:   cmd.mul   = 1'b1;
      ST_DIV:   cmd.load  = sts.out_free;
      default:  cmd       = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mask_r  <= 4'd0;
      k_r     <= 2'd0;
    end else begin
      state_r <= state_nxt;
      mask_r  <= mask_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

### sv/bb3_dp.sv
module bb3_dp #(
  parameter int MAX_WIDTH = bb3_pkg::BB3_MAX_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [bb3_pkg::BB3_CFG_INDEX_W-1:0] cfg_index,
  input  logic [bb3_pkg::BB3_CFG_DATA_W-1:0]  cfg_data,
  input  logic [bb3_pkg::BB3_PIX_W-1:0]       in_tdata,
  input  bb3_pkg::bb3_cmd_t                   cmd,
  output bb3_pkg::bb3_sts_t                   sts,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bb3_pkg::BB3_PIX_W-1:0]       out_tdata,
  output logic                                out_tlast,
  output logic                                out_tuser
);
  import bb3_pkg::*;

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int CSW = WW + 2;

  // configuration
  logic [11:0] width_r;
  logic [15:0] height_r;
  logic [WW-1:0] w_eff;
  logic [15:0]   h_eff;
  logic          cfg_hit;

  assign cfg_hit = cfg_valid &&
                   (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_IMAGE_WIDTH)  width_r  <= cfg_data[11:0];
      if (cfg_index == REG_IMAGE_HEIGHT) height_r <= cfg_data;
    end
  end

  always_comb begin
    if (width_r == 12'd0)                  w_eff = WW'(1);
    else if (32'(width_r) > MAX_WIDTH)     w_eff = WW'(MAX_WIDTH);
    else                                   w_eff = WW'(width_r);
    h_eff = (height_r == 16'd0) ? 16'd1 : height_r;
  end

  // position of the next input pixel
  logic [AW-1:0] col_r, cur_c_r;
  logic [15:0]   row_r, cur_r_r;
  logic          wrap;
  logic [AW-1:0] c_in;
  logic [15:0]   r_in;
  logic          last_col_in, last_row_in;

  assign wrap        = (WW'(col_r) >= w_eff) || (row_r >= h_eff);
  assign c_in        = wrap ? '0 : col_r;
  assign r_in        = wrap ? 16'd0 : row_r;
  assign last_col_in = (WW'(c_in) == w_eff - WW'(1));
  assign last_row_in = (r_in == h_eff - 16'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= 16'd0;
    end else if (cfg_hit) begin
      col_r <= '0;
      row_r <= 16'd0;
    end else if (cmd.accept) begin
      if (last_col_in) begin
        col_r <= '0;
        row_r <= last_row_in ? 16'd0 : r_in + 16'd1;
      end else begin
        col_r <= c_in + AW'(1);
        row_r <= r_in;
      end
    end
  end

  logic [BB3_PIX_W-1:0] px_r;
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_c_r <= c_in;
      cur_r_r <= r_in;
      px_r    <= in_tdata;
    end
  end

  // line buffers: rows r-2 and r-1
  logic [BB3_PIX_W-1:0] older_mem [MAX_WIDTH];
  logic [BB3_PIX_W-1:0] newer_mem [MAX_WIDTH];
  logic [BB3_PIX_W-1:0] rd_old_r, rd_new_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_old_r <= older_mem[c_in];
      rd_new_r <= newer_mem[c_in];
    end
    if (cmd.shift) begin
      older_mem[cur_c_r] <= rd_new_r;
      newer_mem[cur_c_r] <= px_r;
    end
  end

  // 3x3 window, column 2 is the newest
  logic [BB3_PIX_W-1:0] win_r [9];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else if (cmd.shift) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k*3]   <= win_r[k*3+1];
        win_r[k*3+1] <= win_r[k*3+2];
      end
      win_r[2] <= rd_old_r;
      win_r[5] <= rd_new_r;
      win_r[8] <= px_r;
    end
  end

  // which window rows and columns lie inside the image
  logic [2:0]     row_ok, col_ok;
  logic [17:0]    rs;
  logic [CSW-1:0] cs;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rs = {2'b00, cur_r_r} + 18'(i);
      row_ok[i] = (rs >= 18'd2) && (rs <= {2'b00, h_eff} + 18'd1);
      cs = CSW'(cur_c_r) + CSW'(i);
      col_ok[i] = (cs >= CSW'(2)) && (cs <= CSW'(w_eff) + CSW'(1));
    end
  end

  // results due for this pixel
  logic c_ge1, r_ge1, lcol, lrow;
  assign c_ge1 = (cur_c_r != '0);
  assign r_ge1 = (cur_r_r != 16'd0);
  assign lcol  = (WW'(cur_c_r) == w_eff - WW'(1));
  assign lrow  = (cur_r_r == h_eff - 16'd1);

  assign sts.emit_mask = {lrow && lcol, lrow && c_ge1, r_ge1 && lcol, r_ge1 && c_ge1};
  assign sts.out_free  = !out_tvalid || out_tready;

  // stage 1: neighbourhood sums and count
  logic [11:0] sum_c  [3];
  logic [11:0] sum_r  [3];
  logic [3:0]  n_c, n_r;
  logic [1:0]  trow, tcol;
  logic        use_cell;
  always_comb begin
    trow = cmd.k[1] ? 2'd2 : 2'd1;
    tcol = cmd.k[0] ? 2'd2 : 2'd1;
    n_c  = 4'd0;
    for (int ch = 0; ch < 3; ch++) sum_c[ch] = 12'd0;
    for (int wr = 0; wr < 3; wr++) begin
      for (int wc = 0; wc < 3; wc++) begin
        use_cell = (wr + 1 >= int'(trow)) && (wr <= int'(trow) + 1) &&
                   (wc + 1 >= int'(tcol)) && (wc <= int'(tcol) + 1) &&
                   row_ok[wr] && col_ok[wc];
        if (use_cell) begin
          n_c = n_c + 4'd1;
          for (int ch = 0; ch < 3; ch++)
            sum_c[ch] = sum_c[ch] + 12'(win_r[wr*3+wc][ch*8 +: 8]);
        end
      end
    end
    if (n_c == 4'd0) n_c = 4'd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      for (int ch = 0; ch < 3; ch++) sum_r[ch] <= sum_c[ch];
      n_r <= n_c;
    end
  end

  // stage 2: reciprocal multiply, quotient estimate low by at most one
  logic [12:0] x_c  [3];
  logic [28:0] prod [3];
  logic [12:0] x_r  [3];
  logic [7:0]  q_r  [3];
  logic [4:0]  d_r;
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      x_c[ch]  = {sum_r[ch], 1'b0} + 13'(n_r);
      prod[ch] = 29'(x_c[ch]) * 29'(bb3_recip(n_r));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      for (int ch = 0; ch < 3; ch++) begin
        x_r[ch] <= x_c[ch];
        q_r[ch] <= prod[ch][23:16];
      end
      d_r <= {n_r, 1'b0};
    end
  end

  // stage 3: remainder correction
  logic [12:0] qd  [3];
  logic [12:0] rem [3];
  logic [BB3_PIX_W-1:0] mean_c;
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      qd[ch]  = 13'(q_r[ch]) * 13'(d_r);
      rem[ch] = x_r[ch] - qd[ch];
      mean_c[ch*8 +: 8] = (rem[ch] >= 13'(d_r)) ? q_r[ch] + 8'd1 : q_r[ch];
    end
  end

  // output register
  logic                 out_valid_r;
  logic [BB3_PIX_W-1:0] out_data_r;
  logic                 out_last_r, out_user_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r <= mean_c;
      out_last_r <= cmd.last;
      out_user_r <= (cmd.k == 2'd3);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

endmodule
